// ===== sv/dwr_pkg.sv =====
package dwr_pkg;

    localparam int KW = 16;
    localparam int CMD_W = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_SWAP       = 3'd4,
        CMD_ROTATE     = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_PUSH_F,
        OP_PUSH_B,
        OP_RD_HEAD,
        OP_RD_LAST,
        OP_POP_F,
        OP_POP_B,
        OP_SW_LAST,
        OP_WR_HEAD,
        OP_WR_LAST,
        OP_DIV_START,
        OP_ROT_LOAD,
        OP_ROT_WR,
        OP_EMIT
    } t_dp_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POP_F,
        S_POP_B,
        S_SW_LAST,
        S_SW_HEAD,
        S_SW_TAIL,
        S_DIV,
        S_ROT_RD,
        S_ROT_WR,
        S_FIN
    } t_state;

    typedef struct packed {
        t_cmd cmd;
        logic err;
        logic count_zero;
        logic div_busy;
        logic rot_zero;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== sv/dwr_mod.sv =====
module dwr_mod #(
    parameter int DW = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [dwr_pkg::KW-1:0] i_k,
    input  logic [DW-1:0]         i_div,
    output logic [DW-1:0]         o_rem,
    output logic                  o_busy
);

    localparam int CNTW = $clog2(dwr_pkg::KW + 1);

    logic                   r_busy;
    logic [CNTW-1:0]        r_cnt;
    logic [dwr_pkg::KW-1:0] r_k;
    logic [DW-1:0]          r_rem;
    logic [DW-1:0]          r_div;

    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic [DW-1:0] n_rem;

    always_comb begin
        shifted = {r_rem, r_k[dwr_pkg::KW-1]};
        diff    = shifted - {1'b0, r_div};
        if (shifted >= {1'b0, r_div}) begin
            n_rem = diff[DW-1:0];
        end else begin
            n_rem = shifted[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == CNTW'(1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_k   <= i_k;
            r_rem <= '0;
            r_cnt <= CNTW'(dwr_pkg::KW);
            r_div <= i_div;
        end else if (r_busy) begin
            r_k   <= r_k << 1;
            r_rem <= n_rem;
            r_cnt <= r_cnt - CNTW'(1);
        end
    end

    assign o_rem  = r_rem;
    assign o_busy = r_busy;

endmodule

// ===== sv/dwr_dp.sv =====
module dwr_dp #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dwr_pkg::t_dp_op               i_op,
    output dwr_pkg::t_dp_stat             o_stat,
    input  logic [dwr_pkg::CMD_W-1:0]     i_cmd,
    input  logic [DATA_WIDTH-1:0]         i_data_in,
    input  logic [dwr_pkg::KW-1:0]        i_rotate_count,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [DATA_WIDTH-1:0]         o_data_out,
    output logic [dwr_pkg::STATUS_W-1:0]  o_status,
    output logic [$clog2(DEPTH+1)-1:0]    o_occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];

    logic [AW-1:0]          r_head;
    logic [CW-1:0]          r_count;
    logic                   r_out_valid;
    dwr_pkg::t_cmd          r_cmd;
    logic [DATA_WIDTH-1:0]  r_data;
    logic [dwr_pkg::KW-1:0] r_k;
    logic [DATA_WIDTH-1:0]  r_tmp;
    logic [DATA_WIDTH-1:0]  r_rdata;
    logic [DATA_WIDTH-1:0]  r_res_data;
    dwr_pkg::t_status       r_res_status;
    logic [CW-1:0]          r_rot_left;
    logic [DATA_WIDTH-1:0]  r_out_data;
    dwr_pkg::t_status       r_out_status;
    logic [CW-1:0]          r_out_occ;

    logic [AW-1:0]         head_prev;
    logic [AW-1:0]         head_next;
    logic [SW-1:0]         sum_last;
    logic [SW-1:0]         sum_back;
    logic [SW-1:0]         wrap_last;
    logic [SW-1:0]         wrap_back;
    logic [AW-1:0]         slot_last;
    logic [AW-1:0]         slot_back;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    dwr_pkg::t_status      new_status;
    logic                  out_free;
    logic [CW-1:0]         div_rem;
    logic                  div_busy;
    logic                  is_full;
    logic                  is_empty;

    dwr_mod #(
        .DW(CW)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_op == dwr_pkg::OP_DIV_START),
        .i_k     (r_k),
        .i_div   (r_count),
        .o_rem   (div_rem),
        .o_busy  (div_busy)
    );

    // ring index arithmetic; slots wrap at DEPTH
    always_comb begin
        head_prev = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
        head_next = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
        sum_last  = SW'(r_head) + SW'(r_count) - SW'(1);
        sum_back  = SW'(r_head) + SW'(r_count);
        wrap_last = (sum_last >= SW'(DEPTH)) ? sum_last - SW'(DEPTH) : sum_last;
        wrap_back = (sum_back >= SW'(DEPTH)) ? sum_back - SW'(DEPTH) : sum_back;
        slot_last = wrap_last[AW-1:0];
        slot_back = wrap_back[AW-1:0];
        is_full   = (r_count == CW'(DEPTH));
        is_empty  = (r_count == '0);
        out_free  = !r_out_valid || !i_out_stall;
    end

    always_comb begin
        unique case (dwr_pkg::t_cmd'(i_cmd))
            dwr_pkg::CMD_PUSH_FRONT,
            dwr_pkg::CMD_PUSH_BACK: begin
                new_status = is_full ? dwr_pkg::ST_FULL : dwr_pkg::ST_OK;
            end
            dwr_pkg::CMD_POP_FRONT,
            dwr_pkg::CMD_POP_BACK,
            dwr_pkg::CMD_SWAP: begin
                new_status = is_empty ? dwr_pkg::ST_EMPTY : dwr_pkg::ST_OK;
            end
            default: begin
                new_status = dwr_pkg::ST_OK;
            end
        endcase
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_head;
        wr_en   = 1'b0;
        wr_addr = r_head;
        wr_data = r_data;
        unique case (i_op)
            dwr_pkg::OP_RD_HEAD: begin
                rd_en = 1'b1;
            end
            dwr_pkg::OP_RD_LAST,
            dwr_pkg::OP_SW_LAST: begin
                rd_en   = 1'b1;
                rd_addr = slot_last;
            end
            dwr_pkg::OP_PUSH_F: begin
                wr_en   = 1'b1;
                wr_addr = head_prev;
            end
            dwr_pkg::OP_PUSH_B: begin
                wr_en   = 1'b1;
                wr_addr = slot_back;
            end
            dwr_pkg::OP_WR_HEAD: begin
                wr_en   = 1'b1;
                wr_data = r_rdata;
            end
            dwr_pkg::OP_WR_LAST: begin
                wr_en   = 1'b1;
                wr_addr = slot_last;
                wr_data = r_tmp;
            end
            dwr_pkg::OP_ROT_WR: begin
                wr_en   = 1'b1;
                wr_addr = head_prev;
                wr_data = r_rdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (i_op)
                dwr_pkg::OP_PUSH_F: begin
                    r_head  <= head_prev;
                    r_count <= r_count + CW'(1);
                end
                dwr_pkg::OP_PUSH_B: begin
                    r_count <= r_count + CW'(1);
                end
                dwr_pkg::OP_POP_F: begin
                    r_head  <= head_next;
                    r_count <= r_count - CW'(1);
                end
                dwr_pkg::OP_POP_B: begin
                    r_count <= r_count - CW'(1);
                end
                dwr_pkg::OP_ROT_WR: begin
                    r_head <= head_prev;
                end
                default: begin
                end
            endcase
            if (i_op == dwr_pkg::OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            dwr_pkg::OP_LATCH: begin
                r_cmd        <= dwr_pkg::t_cmd'(i_cmd);
                r_data       <= i_data_in;
                r_k          <= i_rotate_count;
                r_res_data   <= '0;
                r_res_status <= new_status;
            end
            dwr_pkg::OP_POP_F,
            dwr_pkg::OP_POP_B: begin
                r_res_data <= r_rdata;
            end
            dwr_pkg::OP_SW_LAST: begin
                r_tmp <= r_rdata;
            end
            dwr_pkg::OP_ROT_LOAD: begin
                r_rot_left <= div_rem;
            end
            dwr_pkg::OP_ROT_WR: begin
                r_rot_left <= r_rot_left - CW'(1);
            end
            dwr_pkg::OP_EMIT: begin
                r_out_data   <= r_res_data;
                r_out_status <= r_res_status;
                r_out_occ    <= r_count;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_stat.cmd        = r_cmd;
        o_stat.err        = (r_res_status != dwr_pkg::ST_OK);
        o_stat.count_zero = is_empty;
        o_stat.div_busy   = div_busy;
        o_stat.rot_zero   = (r_rot_left == '0);
        o_stat.out_free   = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_out_data;
    assign o_status    = r_out_status;
    assign o_occupancy = r_out_occ;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op == dwr_pkg::OP_PUSH_F |=> r_count == $past(r_count) + CW'(1))
        else $error("front push did not grow count");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op == dwr_pkg::OP_EMIT |-> out_free)
        else $error("result overwritten before taken");

    a_rot_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op == dwr_pkg::OP_ROT_WR |-> r_rot_left != '0)
        else $error("rotate step with no moves left");

endmodule

// ===== sv/dwr_ctrl.sv =====
module dwr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  dwr_pkg::t_dp_stat i_stat,
    output dwr_pkg::t_dp_op   o_op
);

    dwr_pkg::t_state r_state;
    dwr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dwr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dwr_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = dwr_pkg::S_DECODE;
                end
            end
            dwr_pkg::S_DECODE: begin
                if (i_stat.err) begin
                    n_state = dwr_pkg::S_FIN;
                end else begin
                    unique case (i_stat.cmd)
                        dwr_pkg::CMD_POP_FRONT: n_state = dwr_pkg::S_POP_F;
                        dwr_pkg::CMD_POP_BACK:  n_state = dwr_pkg::S_POP_B;
                        dwr_pkg::CMD_SWAP:      n_state = dwr_pkg::S_SW_LAST;
                        dwr_pkg::CMD_ROTATE: begin
                            n_state = i_stat.count_zero ? dwr_pkg::S_FIN : dwr_pkg::S_DIV;
                        end
                        default:                n_state = dwr_pkg::S_FIN;
                    endcase
                end
            end
            dwr_pkg::S_POP_F:   n_state = dwr_pkg::S_FIN;
            dwr_pkg::S_POP_B:   n_state = dwr_pkg::S_FIN;
            dwr_pkg::S_SW_LAST: n_state = dwr_pkg::S_SW_HEAD;
            dwr_pkg::S_SW_HEAD: n_state = dwr_pkg::S_SW_TAIL;
            dwr_pkg::S_SW_TAIL: n_state = dwr_pkg::S_FIN;
            dwr_pkg::S_DIV: begin
                if (!i_stat.div_busy) begin
                    n_state = dwr_pkg::S_ROT_RD;
                end
            end
            dwr_pkg::S_ROT_RD: begin
                n_state = i_stat.rot_zero ? dwr_pkg::S_FIN : dwr_pkg::S_ROT_WR;
            end
            dwr_pkg::S_ROT_WR:  n_state = dwr_pkg::S_ROT_RD;
            dwr_pkg::S_FIN: begin
                if (i_stat.out_free) begin
                    n_state = dwr_pkg::S_IDLE;
                end
            end
            default:            n_state = dwr_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_op       = dwr_pkg::OP_NONE;
        o_in_stall = (r_state != dwr_pkg::S_IDLE);
        unique case (r_state)
            dwr_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_op = dwr_pkg::OP_LATCH;
                end
            end
            dwr_pkg::S_DECODE: begin
                if (!i_stat.err) begin
                    unique case (i_stat.cmd)
                        dwr_pkg::CMD_PUSH_FRONT: o_op = dwr_pkg::OP_PUSH_F;
                        dwr_pkg::CMD_PUSH_BACK:  o_op = dwr_pkg::OP_PUSH_B;
                        dwr_pkg::CMD_POP_FRONT:  o_op = dwr_pkg::OP_RD_HEAD;
                        dwr_pkg::CMD_POP_BACK:   o_op = dwr_pkg::OP_RD_LAST;
                        dwr_pkg::CMD_SWAP:       o_op = dwr_pkg::OP_RD_HEAD;
                        dwr_pkg::CMD_ROTATE: begin
                            if (!i_stat.count_zero) begin
                                o_op = dwr_pkg::OP_DIV_START;
                            end
                        end
                        default:                 o_op = dwr_pkg::OP_NONE;
                    endcase
                end
            end
            dwr_pkg::S_POP_F:   o_op = dwr_pkg::OP_POP_F;
            dwr_pkg::S_POP_B:   o_op = dwr_pkg::OP_POP_B;
            dwr_pkg::S_SW_LAST: o_op = dwr_pkg::OP_SW_LAST;
            dwr_pkg::S_SW_HEAD: o_op = dwr_pkg::OP_WR_HEAD;
            dwr_pkg::S_SW_TAIL: o_op = dwr_pkg::OP_WR_LAST;
            dwr_pkg::S_DIV: begin
                if (!i_stat.div_busy) begin
                    o_op = dwr_pkg::OP_ROT_LOAD;
                end
            end
            dwr_pkg::S_ROT_RD: begin
                if (!i_stat.rot_zero) begin
                    o_op = dwr_pkg::OP_RD_LAST;
                end
            end
            dwr_pkg::S_ROT_WR:  o_op = dwr_pkg::OP_ROT_WR;
            dwr_pkg::S_FIN: begin
                if (i_stat.out_free) begin
                    o_op = dwr_pkg::OP_EMIT;
                end
            end
            default:            o_op = dwr_pkg::OP_NONE;
        endcase
    end

    a_stall_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_op == dwr_pkg::OP_LATCH |-> !o_in_stall && i_in_valid)
        else $error("command latched outside idle");

    a_latch_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_op == dwr_pkg::OP_LATCH |=> r_state == dwr_pkg::S_DECODE)
        else $error("latched command not decoded");

    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_op == dwr_pkg::OP_EMIT |=> r_state == dwr_pkg::S_IDLE)
        else $error("controller busy after result");

endmodule

// ===== sv/deque_with_rotate.sv =====
// Bounded double-ended queue of DEPTH signed entries in a ring buffer, one
// command per input beat (push front/back, pop front/back, swap ends, rotate
// right by rotate_count mod occupancy) and one result beat per command. One
// command is in flight at a time; the next input beat is taken as soon as the
// previous result is loaded into the output register, even while that beat is
// still stalled. Commands step through states over the single-port entry memory
// and the bit-serial remainder unit; a rotate with entries present reduces the
// amount in 16 remainder steps, then reads and writes once per entry moved.
module deque_with_rotate #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [dwr_pkg::CMD_W-1:0]           i_cmd,
    input  logic signed [DATA_WIDTH-1:0]        i_data_in,
    input  logic [dwr_pkg::KW-1:0]              i_rotate_count,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [DATA_WIDTH-1:0]        o_data_out,
    output logic [dwr_pkg::STATUS_W-1:0]        o_status,
    output logic [$clog2(DEPTH+1)-1:0]          o_occupancy
);

    dwr_pkg::t_dp_op   op;
    dwr_pkg::t_dp_stat stat;
    logic [DATA_WIDTH-1:0] data_out;

    dwr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_op       (op)
    );

    dwr_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .o_stat         (stat),
        .i_cmd          (i_cmd),
        .i_data_in      (i_data_in),
        .i_rotate_count (i_rotate_count),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_data_out     (data_out),
        .o_status       (o_status),
        .o_occupancy    (o_occupancy)
    );

    assign o_data_out = data_out;

endmodule

// ===== dv/tb_deque_with_rotate.sv =====
`timescale 1ns / 100ps

module tb_deque_with_rotate;

    localparam int DEPTH       = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int OCC_W       = $clog2(DEPTH + 1);
    localparam int CMD_W       = dwr_pkg::CMD_W;
    localparam int ROT_W       = dwr_pkg::KW;
    localparam int STATUS_W    = dwr_pkg::STATUS_W;
    localparam int CLK_PERIOD  = 10;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_BEATS = 1700;
    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = 64;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AT     = 800;
    localparam int PHASE_LEN   = 150;

    localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

    localparam logic signed [DATA_WIDTH-1:0] DATA_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_WIDTH-1:0] DATA_MIN = 32'sh8000_0000;

    typedef struct {
        logic [CMD_W-1:0]             cmd;
        logic signed [DATA_WIDTH-1:0] data;
        logic [ROT_W-1:0]             rot;
        bit                           drain_first;
    } t_deque_cmd;

    typedef struct {
        logic signed [DATA_WIDTH-1:0] data;
        logic [STATUS_W-1:0]          status;
        logic [OCC_W-1:0]             occ;
    } t_deque_res;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    logic [CMD_W-1:0]             i_cmd = '0;
    logic signed [DATA_WIDTH-1:0] i_data_in = '0;
    logic [ROT_W-1:0]             i_rotate_count = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic signed [DATA_WIDTH-1:0] o_data_out;
    logic [STATUS_W-1:0]          o_status;
    logic [OCC_W-1:0]             o_occupancy;

    // shadow deque
    logic [DATA_WIDTH-1:0] dq_mem [DEPTH];
    logic [3:0]            dq_head = '0;
    logic [OCC_W-1:0]      dq_count = '0;

    t_deque_cmd cmd_backlog[$];
    t_deque_res pending_results[$];
    t_deque_cmd cur_cmd;
    t_deque_res pred_res;
    t_deque_res got_res;
    int         n_sent = 0;
    int         n_total = 0;
    int         n_errors = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;
    int         cycles = 0;

    deque_with_rotate #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_data_in      (i_data_in),
        .i_rotate_count (i_rotate_count),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_data_out     (o_data_out),
        .o_status       (o_status),
        .o_occupancy    (o_occupancy)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic deque_apply(input t_deque_cmd c, output t_deque_res r);
        logic [3:0] slot;
        logic [3:0] last_slot;
        logic [DATA_WIDTH-1:0] tmp;
        int rot_left;
        r.data   = '0;
        r.status = dwr_pkg::ST_OK;
        case (c.cmd)
            dwr_pkg::CMD_PUSH_FRONT: begin
                if (dq_count == DEPTH) begin
                    r.status = dwr_pkg::ST_FULL;
                end else begin
                    dq_head = dq_head - 4'd1;
                    dq_mem[dq_head] = c.data;
                    dq_count = dq_count + 1'b1;
                end
            end
            dwr_pkg::CMD_PUSH_BACK: begin
                if (dq_count == DEPTH) begin
                    r.status = dwr_pkg::ST_FULL;
                end else begin
                    slot = dq_head + dq_count[3:0];
                    dq_mem[slot] = c.data;
                    dq_count = dq_count + 1'b1;
                end
            end
            dwr_pkg::CMD_POP_FRONT: begin
                if (dq_count == 0) begin
                    r.status = dwr_pkg::ST_EMPTY;
                end else begin
                    r.data = dq_mem[dq_head];
                    dq_head = dq_head + 4'd1;
                    dq_count = dq_count - 1'b1;
                end
            end
            dwr_pkg::CMD_POP_BACK: begin
                if (dq_count == 0) begin
                    r.status = dwr_pkg::ST_EMPTY;
                end else begin
                    last_slot = dq_head + dq_count[3:0] - 4'd1;
                    r.data = dq_mem[last_slot];
                    dq_count = dq_count - 1'b1;
                end
            end
            dwr_pkg::CMD_SWAP: begin
                if (dq_count == 0) begin
                    r.status = dwr_pkg::ST_EMPTY;
                end else begin
                    last_slot = dq_head + dq_count[3:0] - 4'd1;
                    tmp = dq_mem[dq_head];
                    dq_mem[dq_head] = dq_mem[last_slot];
                    dq_mem[last_slot] = tmp;
                end
            end
            dwr_pkg::CMD_ROTATE: begin
                if (dq_count != 0) begin
                    rot_left = int'(c.rot) % int'(dq_count);
                    for (int i = 0; i < rot_left; i++) begin
                        last_slot = dq_head + dq_count[3:0] - 4'd1;
                        dq_head = dq_head - 4'd1;
                        dq_mem[dq_head] = dq_mem[last_slot];
                    end
                end
            end
            default: begin
            end
        endcase
        r.occ = dq_count;
    endtask

    function automatic int sender_idle_pct();
        int ph;
        ph = (n_sent / PHASE_LEN) % 4;
        if (hold_left > 0) return 0;
        if (ph == 1) return 62;
        if (ph == 3) return 9;
        return 0;
    endfunction

    function automatic int recv_stall_pct();
        int ph;
        ph = (n_sent / PHASE_LEN) % 4;
        if (ph == 2) return 62;
        if (ph == 3) return 9;
        return 0;
    endfunction

    task automatic add_cmd(input logic [CMD_W-1:0] cmd, input logic signed [DATA_WIDTH-1:0] data,
                           input logic [ROT_W-1:0] rot, input bit drain_first);
        t_deque_cmd c;
        c.cmd = cmd;
        c.data = data;
        c.rot = rot;
        c.drain_first = drain_first;
        cmd_backlog.push_back(c);
    endtask

    function automatic logic signed [DATA_WIDTH-1:0] rand_data();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return DATA_MAX;
        if (sel == 1) return DATA_MIN;
        if (sel == 2) return '0;
        if (sel == 3) return '1;
        return $urandom;
    endfunction

    function automatic logic [ROT_W-1:0] rand_rot();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) return ROT_W'($urandom_range(0, 40));
        if (sel == 5) return {ROT_W{1'b1}};
        return ROT_W'($urandom_range(0, 65535));
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                deque_apply(cur_cmd, pred_res);
                pending_results.push_back(pred_res);
                n_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (cmd_backlog.size() != 0
                    && !(cmd_backlog[0].drain_first && pending_results.size() != 0)
                    && $urandom_range(0, 99) >= sender_idle_pct()) begin
                    cur_cmd = cmd_backlog.pop_front();
                    i_in_valid     <= 1'b1;
                    i_cmd          <= cur_cmd.cmd;
                    i_data_in      <= cur_cmd.data;
                    i_rotate_count <= cur_cmd.rot;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall, with one long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (!hold_done && n_sent >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct());
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result beat: data_out %h status %0d occupancy %0d",
                         $time, o_data_out, o_status, o_occupancy);
                n_errors++;
            end else begin
                got_res = pending_results.pop_front();
                if (o_data_out !== got_res.data) begin
                    $display("%0t data_out mismatch: expected %h actual %h",
                             $time, got_res.data, o_data_out);
                    n_errors++;
                end
                if (o_status !== got_res.status) begin
                    $display("%0t status mismatch: expected %0d actual %0d",
                             $time, got_res.status, o_status);
                    n_errors++;
                end
                if (o_occupancy !== got_res.occ) begin
                    $display("%0t occupancy mismatch: expected %0d actual %0d",
                             $time, got_res.occ, o_occupancy);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int mode;
        int sel;
        logic [CMD_W-1:0] cmd;

        // empty cases and unused codes
        add_cmd(dwr_pkg::CMD_POP_FRONT, '0, '0, 1'b0);
        add_cmd(dwr_pkg::CMD_POP_BACK, '0, '0, 1'b0);
        add_cmd(dwr_pkg::CMD_SWAP, '0, '0, 1'b0);
        add_cmd(dwr_pkg::CMD_ROTATE, '0, 16'd5, 1'b0);
        add_cmd(CMD_UNUSED_6, DATA_MAX, 16'd3, 1'b0);
        add_cmd(CMD_UNUSED_7, DATA_MIN, {ROT_W{1'b1}}, 1'b0);
        // single entry
        add_cmd(dwr_pkg::CMD_PUSH_BACK, DATA_MAX, '0, 1'b0);
        add_cmd(dwr_pkg::CMD_SWAP, '0, '0, 1'b0);
        add_cmd(dwr_pkg::CMD_ROTATE, '0, {ROT_W{1'b1}}, 1'b0);
        add_cmd(dwr_pkg::CMD_POP_BACK, '0, '0, 1'b0);
        // fill to full, then full pushes, rotates and a swap
        for (int i = 0; i < DEPTH; i++) begin
            if (i == 0) add_cmd(dwr_pkg::CMD_PUSH_FRONT, DATA_MIN, '0, 1'b0);
            else if (i == 1) add_cmd(dwr_pkg::CMD_PUSH_BACK, '1, '0, 1'b0);
            else if (i == 2) add_cmd(dwr_pkg::CMD_PUSH_FRONT, '0, '0, 1'b0);
            else add_cmd((i % 2) ? dwr_pkg::CMD_PUSH_BACK : dwr_pkg::CMD_PUSH_FRONT,
                         $urandom, '0, 1'b0);
        end
        add_cmd(dwr_pkg::CMD_PUSH_FRONT, DATA_MAX, '0, 1'b0);
        add_cmd(dwr_pkg::CMD_PUSH_BACK, DATA_MIN, '0, 1'b0);
        add_cmd(dwr_pkg::CMD_ROTATE, '0, 16'd32, 1'b0);
        add_cmd(dwr_pkg::CMD_ROTATE, '0, {ROT_W{1'b1}}, 1'b0);
        add_cmd(dwr_pkg::CMD_SWAP, '0, '0, 1'b0);

        // random part: push-heavy, pop-heavy and balanced stretches
        mode = 0;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 40 == 0) mode = $urandom_range(0, 2);
            sel = $urandom_range(0, 99);
            if (sel < 2) begin
                cmd = $urandom_range(0, 1) ? CMD_UNUSED_7 : CMD_UNUSED_6;
            end else if (sel < 12) begin
                cmd = dwr_pkg::CMD_SWAP;
            end else if (sel < 26) begin
                cmd = dwr_pkg::CMD_ROTATE;
            end else begin
                sel = $urandom_range(0, 99);
                if (mode == 0) sel = (sel < 70) ? 0 : 1;
                else if (mode == 1) sel = (sel < 30) ? 0 : 1;
                else sel = (sel < 50) ? 0 : 1;
                if (sel == 0) begin
                    cmd = $urandom_range(0, 1) ? dwr_pkg::CMD_PUSH_BACK
                                               : dwr_pkg::CMD_PUSH_FRONT;
                end else begin
                    cmd = $urandom_range(0, 1) ? dwr_pkg::CMD_POP_BACK
                                               : dwr_pkg::CMD_POP_FRONT;
                end
            end
            add_cmd(cmd, rand_data(), rand_rot(), (n == 1300));
        end
        n_total = cmd_backlog.size();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_sent < n_total || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/dwr_pkg.sv
sv/dwr_mod.sv
sv/dwr_dp.sv
sv/dwr_ctrl.sv
sv/deque_with_rotate.sv
dv/tb_deque_with_rotate.sv
